// ===== hdl/ast_pkg.sv =====
package ast_pkg;

  localparam int PTR_W = 8;
  localparam int LEN_W = 7;

  typedef enum logic [3:0] {
    M_START,
    M_COMMENT,
    M_SECTION,
    M_STRING,
    M_ESCAPE,
    M_VALUE,
    M_LITERAL,
    M_NUMBER,
    M_TIMEPOINT,
    M_DONE
  } mode_t;

  typedef enum logic [2:0] {
    K_SYM,
    K_SEC,
    K_STR,
    K_VAL,
    K_LAB,
    K_LIT,
    K_NUM,
    K_TIME
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [PTR_W-1:0]   start;
    logic [LEN_W-1:0]   len;
    logic               ovf;
    logic               bad;
  } desc_t;

endpackage

// ===== hdl/ast_ram.sv =====
module ast_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ast_scan.sv =====
module ast_scan #(
  parameter int MAX_TOKEN_CHARS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [20:0]                         code_point,
  input  logic                                end_of_input,
  input  logic [ast_pkg::PTR_W-1:0]           base,
  input  logic                                q_room,
  output logic                                push0,
  output ast_pkg::desc_t                      d0,
  output logic                                push1,
  output ast_pkg::desc_t                      d1,
  output logic                                ram_we,
  output logic [$clog2(MAX_TOKEN_CHARS):0]    ram_waddr,
  output logic [20:0]                         ram_wdata
);

  localparam int AW   = $clog2(MAX_TOKEN_CHARS) + 1;
  localparam int PW   = AW + 1;
  localparam int LW   = $clog2(MAX_TOKEN_CHARS + 1);
  localparam int RING = 1 << AW;
  localparam int TIMEPOINT_LEN = 19;

  localparam logic [20:0] CH_LF      = 21'd10;
  localparam logic [20:0] CH_DQUOTE  = 21'd34;
  localparam logic [20:0] CH_SQUOTE  = 21'd39;
  localparam logic [20:0] CH_DOT     = 21'd46;
  localparam logic [20:0] CH_COLON   = 21'd58;
  localparam logic [20:0] CH_SEMI    = 21'd59;
  localparam logic [20:0] CH_AT      = 21'd64;
  localparam logic [20:0] CH_BSLASH  = 21'd92;
  localparam logic [20:0] CH_USCORE  = 21'd95;
  localparam logic [20:0] CH_PILCROW = 21'd182;

  function automatic logic is_space(input logic [20:0] ch);
    return (ch == 21'd32) || (ch >= 21'd9 && ch <= 21'd13);
  endfunction

  function automatic logic is_letter(input logic [20:0] ch);
    return (ch >= 21'd65 && ch <= 21'd90) || (ch >= 21'd97 && ch <= 21'd122);
  endfunction

  function automatic logic is_digit(input logic [20:0] ch);
    return ch >= 21'd48 && ch <= 21'd57;
  endfunction

  function automatic logic is_symbol(input logic [20:0] ch);
    return ch == 21'd40 || ch == 21'd41 || ch == 21'd91 || ch == 21'd93 ||
           ch == 21'd44 || ch == 21'd42 || ch == 21'd43 || ch == 21'd47 ||
           ch == 21'd45 || ch == 21'd35 || ch == CH_PILCROW;
  endfunction

  function automatic ast_pkg::desc_t mk_desc(input ast_pkg::kind_t k,
                                             input logic [PW-1:0] s,
                                             input logic [LW-1:0] l,
                                             input logic o,
                                             input logic b);
    ast_pkg::desc_t d;
    d.kind  = k;
    d.start = ast_pkg::PTR_W'(s);
    d.len   = ast_pkg::LEN_W'(l);
    d.ovf   = o;
    d.bad   = b;
    return d;
  endfunction

  ast_pkg::mode_t  mode, mode_next;
  logic [PW-1:0]   tok_start, tok_start_next;
  logic [LW-1:0]   tok_len, tok_len_next;
  logic            ovf, ovf_next;

  logic [PW-1:0]   cur_end;
  logic [PW-1:0]   used;
  logic            accept;
  logic            tbad;

  ast_pkg::mode_t  st_mode;
  logic            st_push;
  logic            st_we;
  logic [PW-1:0]   st_tok_start;
  logic [LW-1:0]   st_tok_len;
  ast_pkg::desc_t  st_desc;

  ast_pkg::kind_t  cur_kind;
  logic            do_append;
  logic            do_clear;
  logic            apply_st;

  assign cur_end  = tok_start + PW'(tok_len);
  assign used     = cur_end - base[PW-1:0];
  assign in_ready = (mode == ast_pkg::M_DONE) || (!used[AW] && q_room);
  assign accept   = in_valid && in_ready;
  assign tbad     = ovf || (tok_len != LW'(TIMEPOINT_LEN));

  assign ram_waddr = cur_end[AW-1:0];
  assign ram_wdata = code_point;

  always_comb begin
    st_mode      = ast_pkg::M_START;
    st_push      = 1'b0;
    st_we        = 1'b0;
    st_tok_start = cur_end;
    st_tok_len   = '0;
    st_desc      = mk_desc(ast_pkg::K_SYM, cur_end, LW'(1), 1'b0, 1'b0);
    if (code_point == CH_SEMI) begin
      st_mode = ast_pkg::M_COMMENT;
    end else if (code_point == CH_DOT) begin
      st_mode = ast_pkg::M_SECTION;
    end else if (code_point == CH_DQUOTE) begin
      st_mode = ast_pkg::M_STRING;
    end else if (code_point == CH_SQUOTE) begin
      st_mode = ast_pkg::M_VALUE;
    end else if (code_point == CH_AT) begin
      st_mode = ast_pkg::M_TIMEPOINT;
    end else if (is_symbol(code_point)) begin
      st_push      = 1'b1;
      st_we        = 1'b1;
      st_tok_start = cur_end + PW'(1);
    end else if (is_space(code_point)) begin
      st_mode = ast_pkg::M_START;
    end else if (is_digit(code_point)) begin
      st_mode    = ast_pkg::M_NUMBER;
      st_we      = 1'b1;
      st_tok_len = LW'(1);
    end else if (code_point == CH_COLON) begin
      st_push = 1'b1;
      st_desc = mk_desc(ast_pkg::K_LAB, cur_end, '0, 1'b0, 1'b0);
    end else if (is_letter(code_point) || code_point == CH_USCORE) begin
      st_mode    = ast_pkg::M_LITERAL;
      st_we      = 1'b1;
      st_tok_len = LW'(1);
    end
  end

  always_comb begin
    mode_next      = mode;
    tok_start_next = tok_start;
    tok_len_next   = tok_len;
    ovf_next       = ovf;
    push0          = 1'b0;
    push1          = 1'b0;
    ram_we         = 1'b0;
    cur_kind       = ast_pkg::K_SYM;
    do_append      = 1'b0;
    do_clear       = 1'b0;
    apply_st       = 1'b0;
    if (accept && mode != ast_pkg::M_DONE) begin
      if (end_of_input) begin
        case (mode)
          ast_pkg::M_SECTION: begin
            push0    = 1'b1;
            cur_kind = ast_pkg::K_SEC;
          end
          ast_pkg::M_LITERAL: begin
            push0    = (tok_len != '0);
            cur_kind = ast_pkg::K_LIT;
          end
          ast_pkg::M_NUMBER: begin
            push0    = (tok_len != '0);
            cur_kind = ast_pkg::K_NUM;
          end
          default: begin
            push0 = 1'b0;
          end
        endcase
        do_clear = 1'b1;
      end else begin
        case (mode)
          ast_pkg::M_START: begin
            apply_st = 1'b1;
          end
          ast_pkg::M_COMMENT: begin
            do_clear = (code_point == CH_LF);
            if (code_point != CH_LF) begin
              mode_next = ast_pkg::M_COMMENT;
            end
          end
          ast_pkg::M_SECTION: begin
            if (is_letter(code_point)) begin
              do_append = 1'b1;
            end else begin
              push0    = 1'b1;
              cur_kind = ast_pkg::K_SEC;
              apply_st = 1'b1;
            end
          end
          ast_pkg::M_STRING: begin
            if (code_point == CH_DQUOTE) begin
              push0    = 1'b1;
              cur_kind = ast_pkg::K_STR;
              do_clear = 1'b1;
            end else if (code_point == CH_BSLASH) begin
              mode_next = ast_pkg::M_ESCAPE;
            end else begin
              do_append = 1'b1;
            end
          end
          ast_pkg::M_ESCAPE: begin
            do_append = 1'b1;
            mode_next = ast_pkg::M_STRING;
          end
          ast_pkg::M_VALUE: begin
            if (code_point == CH_SQUOTE) begin
              push0    = 1'b1;
              cur_kind = ast_pkg::K_VAL;
              do_clear = 1'b1;
            end else begin
              do_append = 1'b1;
            end
          end
          ast_pkg::M_LITERAL: begin
            if (code_point == CH_COLON) begin
              push0    = 1'b1;
              cur_kind = ast_pkg::K_LAB;
              do_clear = 1'b1;
            end else if (is_letter(code_point) || is_digit(code_point) ||
                         code_point == CH_USCORE) begin
              do_append = 1'b1;
            end else if (tok_len != '0 || ovf) begin
              push0    = 1'b1;
              cur_kind = ast_pkg::K_LIT;
              apply_st = 1'b1;
            end else begin
              do_clear = 1'b1;
            end
          end
          ast_pkg::M_NUMBER: begin
            if (is_digit(code_point)) begin
              do_append = 1'b1;
            end else begin
              push0    = (tok_len != '0);
              cur_kind = ast_pkg::K_NUM;
              apply_st = 1'b1;
            end
          end
          ast_pkg::M_TIMEPOINT: begin
            if (is_space(code_point)) begin
              push0    = 1'b1;
              cur_kind = ast_pkg::K_TIME;
              do_clear = 1'b1;
            end else begin
              do_append = 1'b1;
            end
          end
          default: begin
            mode_next = mode;
          end
        endcase
      end
    end

    if (do_clear) begin
      mode_next      = end_of_input ? ast_pkg::M_DONE : ast_pkg::M_START;
      tok_start_next = cur_end;
      tok_len_next   = '0;
      ovf_next       = 1'b0;
    end
    if (apply_st) begin
      mode_next      = st_mode;
      tok_start_next = st_tok_start;
      tok_len_next   = st_tok_len;
      ovf_next       = 1'b0;
      push1          = st_push;
      ram_we         = st_we;
    end
    if (do_append) begin
      if (tok_len < LW'(MAX_TOKEN_CHARS)) begin
        ram_we       = 1'b1;
        tok_len_next = tok_len + LW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end

    d0 = mk_desc(cur_kind, tok_start, tok_len, ovf,
                 (cur_kind == ast_pkg::K_TIME) && tbad);
    d1 = st_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= ast_pkg::M_START;
      tok_start <= '0;
      tok_len   <= '0;
      ovf       <= 1'b0;
    end else begin
      mode      <= mode_next;
      tok_start <= tok_start_next;
      tok_len   <= tok_len_next;
      ovf       <= ovf_next;
    end
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    used <= PW'(RING))
    else $error("character ring over-committed");

endmodule

// ===== hdl/ast_descq.sv =====
module ast_descq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push0,
  input  ast_pkg::desc_t d0,
  input  logic           push1,
  input  ast_pkg::desc_t d1,
  output logic           q_room,
  output logic           head_valid,
  output ast_pkg::desc_t head,
  input  logic           pop
);

  localparam int DEPTH = 4;

  ast_pkg::desc_t q [DEPTH];
  logic [1:0]     rd_ptr;
  logic [1:0]     wr_ptr;
  logic [2:0]     cnt;
  logic [1:0]     n_push;

  assign n_push     = {1'b0, push0} + {1'b0, push1};
  assign q_room     = (cnt <= 3'd2);
  assign head_valid = (cnt != 3'd0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push0) begin
      q[wr_ptr] <= d0;
    end
    if (push1) begin
      q[push0 ? wr_ptr + 2'd1 : wr_ptr] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      cnt    <= cnt + 3'(n_push) - 3'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(DEPTH))
    else $error("token queue count out of range");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push0 || push1) |-> (cnt <= 3'd2))
    else $error("token queue pushed without room");

endmodule

// ===== hdl/ast_replay.sv =====
module ast_replay #(
  parameter int MAX_TOKEN_CHARS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             head_valid,
  input  ast_pkg::desc_t                   head,
  output logic                             pop,
  output logic [ast_pkg::PTR_W-1:0]        base,
  output logic                             ram_re,
  output logic [$clog2(MAX_TOKEN_CHARS):0] ram_raddr,
  input  logic [20:0]                      ram_rdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [23:0]                      m_tdata,
  output logic                             m_tlast,
  output logic [7:0]                       m_tuser
);

  localparam int AW = $clog2(MAX_TOKEN_CHARS) + 1;
  localparam int PW = AW + 1;
  localparam int LW = $clog2(MAX_TOKEN_CHARS + 1);

  logic [LW-1:0]  idx;
  logic [LW-1:0]  hlen;
  logic [PW-1:0]  base_r;
  logic           issue;
  logic           is_last;
  logic           p_move;

  logic           p_valid;
  ast_pkg::kind_t p_kind;
  logic           p_cv;
  logic           p_last;
  logic           p_trunc;
  logic           p_bad;

  assign hlen      = head.len[LW-1:0];
  assign p_move    = p_valid && (!m_tvalid || m_tready);
  assign issue     = head_valid && (!p_valid || p_move);
  assign is_last   = (hlen == '0) || (idx + LW'(1) == hlen);
  assign pop       = issue && is_last;
  assign ram_re    = issue && (hlen != '0);
  assign ram_raddr = head.start[AW-1:0] + AW'(idx);
  assign base      = ast_pkg::PTR_W'(base_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      base_r  <= '0;
      p_valid <= 1'b0;
    end else begin
      if (issue) begin
        idx     <= is_last ? '0 : idx + LW'(1);
        p_valid <= 1'b1;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end
      if (pop) begin
        base_r <= head.start[PW-1:0] + PW'(hlen);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_kind  <= head.kind;
      p_cv    <= (hlen != '0);
      p_last  <= is_last;
      p_trunc <= head.ovf;
      p_bad   <= head.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (p_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      m_tdata <= {3'b000, (p_cv ? ram_rdata : 21'd0)};
      m_tlast <= p_last;
      m_tuser <= {2'b00, p_bad, p_trunc, p_cv, p_kind};
    end
  end

  a_empty_single: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !p_cv) |-> p_last)
    else $error("empty token word not marked last");

endmodule

// ===== hdl/assembler_source_tokenizer.sv =====
// Assembler source tokenizer. Each input word carries one code point, or marks
// the end of the source with s_tlast (the code point is then ignored). Every
// finished token is sent as a run of output words, one per character, with
// m_tlast on the last; an empty token gives one word with char_valid low.
// Tokens longer than MAX_TOKEN_CHARS keep their first MAX_TOKEN_CHARS
// characters and carry the truncated flag. After the end mark the block
// ignores all input until reset. The scanner takes one input word per cycle;
// output runs at one word per cycle while m_tready is high, set by the single
// read port of the character ring, so a token of n characters is sent as n
// output words (one if empty). The scanner stalls only when the character ring
// (2^(clog2(MAX_TOKEN_CHARS)+1) entries) is full or the four-entry token
// queue has fewer than two free entries. No clearing pass follows reset.
module assembler_source_tokenizer #(
  parameter int MAX_TOKEN_CHARS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [20:0] code_point
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] token_char
  output logic        m_tlast,   // last_of_token
  output logic [7:0]  m_tuser    // [2:0] token_kind, [3] char_valid,
                                 // [4] truncated, [5] bad_timepoint
);

  localparam int AW = $clog2(MAX_TOKEN_CHARS) + 1;

  logic                         q_room;
  logic                         push0;
  logic                         push1;
  ast_pkg::desc_t               d0;
  ast_pkg::desc_t               d1;
  logic                         head_valid;
  ast_pkg::desc_t               head;
  logic                         pop;
  logic [ast_pkg::PTR_W-1:0]    base;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [20:0]                  ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [20:0]                  ram_rdata;

  ast_scan #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .code_point   (s_tdata[20:0]),
    .end_of_input (s_tlast),
    .base         (base),
    .q_room       (q_room),
    .push0        (push0),
    .d0           (d0),
    .push1        (push1),
    .d1           (d1),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  ast_descq u_descq (
    .clk        (clk),
    .rst        (rst),
    .push0      (push0),
    .d0         (d0),
    .push1      (push1),
    .d1         (d1),
    .q_room     (q_room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ast_ram #(
    .WIDTH (21),
    .DEPTH (1 << AW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ast_replay #(
    .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
  ) u_replay (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .base       (base),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

// ===== tb/assembler_source_tokenizer_test.sv =====
`timescale 1ns / 1ps

localparam int TOKEN_CAP = 32;
localparam int TIMEPOINT_CHARS = 19;
localparam logic [20:0] NEWLINE = 21'd10;
localparam logic [20:0] PILCROW = 21'd182;
localparam int CP_MAX = 1114111;

typedef struct packed {
  ast_pkg::kind_t kind;
  logic           cv;
  logic [20:0]    ch;
  logic           last;
  logic           trunc;
  logic           bad;
} token_word_t;

class token_scoreboard;
  ast_pkg::mode_t mode;
  logic [20:0] chars [TOKEN_CAP];
  int unsigned len;
  bit          ovf;
  token_word_t want_q[$];
  int          errors;

  function new();
    mode = ast_pkg::M_START;
    len = 0;
    ovf = 1'b0;
    errors = 0;
  endfunction

  function bit is_space(logic [20:0] c);
    return c == 21'd32 || (c >= 21'd9 && c <= 21'd13);
  endfunction

  function bit is_letter(logic [20:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function bit is_digit(logic [20:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit is_symbol(logic [20:0] c);
    return c == "(" || c == ")" || c == "[" || c == "]" || c == "," || c == "*" ||
           c == "+" || c == "/" || c == "-" || c == "#" || c == PILCROW;
  endfunction

  function void clear_token();
    len = 0;
    ovf = 1'b0;
  endfunction

  function void add_char(logic [20:0] c);
    if (len < TOKEN_CAP) begin
      chars[len] = c;
      len++;
    end else begin
      ovf = 1'b1;
    end
  endfunction

  function void emit(ast_pkg::kind_t k);
    token_word_t w;
    bit bad;
    bad = (k == ast_pkg::K_TIME) && (ovf || len != TIMEPOINT_CHARS);
    if (len == 0) begin
      w = '{kind: k, cv: 1'b0, ch: '0, last: 1'b1, trunc: ovf, bad: bad};
      want_q.push_back(w);
    end
    for (int i = 0; i < len; i++) begin
      w = '{kind: k, cv: 1'b1, ch: chars[i], last: (i + 1 == len), trunc: ovf, bad: bad};
      want_q.push_back(w);
    end
  endfunction

  function void note_input(logic [20:0] c, bit eoi);
    bit again;
    if (mode == ast_pkg::M_DONE) return;
    if (eoi) begin
      if (mode == ast_pkg::M_SECTION) emit(ast_pkg::K_SEC);
      else if (mode == ast_pkg::M_LITERAL && len != 0) emit(ast_pkg::K_LIT);
      else if (mode == ast_pkg::M_NUMBER && len != 0) emit(ast_pkg::K_NUM);
      clear_token();
      mode = ast_pkg::M_DONE;
      return;
    end
    for (int pass = 0; pass < 4; pass++) begin
      again = 1'b0;
      case (mode)
        ast_pkg::M_START: begin
          clear_token();
          if (c == ";") mode = ast_pkg::M_COMMENT;
          else if (c == ".") mode = ast_pkg::M_SECTION;
          else if (c == "\"") mode = ast_pkg::M_STRING;
          else if (c == "'") mode = ast_pkg::M_VALUE;
          else if (c == "@") mode = ast_pkg::M_TIMEPOINT;
          else if (is_symbol(c)) begin
            add_char(c);
            emit(ast_pkg::K_SYM);
            clear_token();
          end else if (!is_space(c)) begin
            mode = is_digit(c) ? ast_pkg::M_NUMBER : ast_pkg::M_LITERAL;
            again = 1'b1;
          end
        end
        ast_pkg::M_COMMENT: if (c == NEWLINE) mode = ast_pkg::M_START;
        ast_pkg::M_SECTION: begin
          if (is_letter(c)) add_char(c);
          else begin
            emit(ast_pkg::K_SEC);
            mode = ast_pkg::M_START;
            again = 1'b1;
          end
        end
        ast_pkg::M_STRING: begin
          if (c == "\"") begin
            emit(ast_pkg::K_STR);
            mode = ast_pkg::M_START;
          end else if (c == "\\") mode = ast_pkg::M_ESCAPE;
          else add_char(c);
        end
        ast_pkg::M_ESCAPE: begin
          add_char(c);
          mode = ast_pkg::M_STRING;
        end
        ast_pkg::M_VALUE: begin
          if (c == "'") begin
            emit(ast_pkg::K_VAL);
            mode = ast_pkg::M_START;
          end else add_char(c);
        end
        ast_pkg::M_LITERAL: begin
          if (c == ":") begin
            emit(ast_pkg::K_LAB);
            mode = ast_pkg::M_START;
          end else if (is_letter(c) || is_digit(c) || c == "_") add_char(c);
          else if (len != 0 || ovf) begin
            emit(ast_pkg::K_LIT);
            mode = ast_pkg::M_START;
            again = 1'b1;
          end else mode = ast_pkg::M_START;
        end
        ast_pkg::M_NUMBER: begin
          if (is_digit(c)) add_char(c);
          else begin
            if (len != 0) emit(ast_pkg::K_NUM);
            mode = ast_pkg::M_START;
            again = 1'b1;
          end
        end
        ast_pkg::M_TIMEPOINT: begin
          if (is_space(c)) begin
            emit(ast_pkg::K_TIME);
            mode = ast_pkg::M_START;
          end else add_char(c);
        end
        default: mode = ast_pkg::M_DONE;
      endcase
      if (!again) break;
    end
  endfunction

  function void check_word(token_word_t got);
    token_word_t w;
    if (want_q.size() == 0) begin
      errors++;
      $display("%0t: expected no word, actual kind=%0d cv=%0b char=%0h last=%0b trunc=%0b bad=%0b",
               $time, got.kind, got.cv, got.ch, got.last, got.trunc, got.bad);
      return;
    end
    w = want_q.pop_front();
    if (got !== w) begin
      errors++;
      $display("%0t: expected kind=%0d cv=%0b char=%0h last=%0b trunc=%0b bad=%0b",
               $time, w.kind, w.cv, w.ch, w.last, w.trunc, w.bad);
      $display("%0t:   actual kind=%0d cv=%0b char=%0h last=%0b trunc=%0b bad=%0b",
               $time, got.kind, got.cv, got.ch, got.last, got.trunc, got.bad);
    end
  endfunction

  function int pending();
    return want_q.size();
  endfunction
endclass

module assembler_source_tokenizer_test;
  localparam int MAX_CYCLES = 1000000;
  localparam int RANDOM_ITEMS = 320;

  typedef struct packed {
    logic [20:0] cp;
    logic        eoi;
  } src_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic [7:0]  m_tuser;

  token_scoreboard sb;
  src_word_t       src_q[$];
  bit              idle_on = 1'b1;
  int              cycles = 0;
  int              directed_n;

  assembler_source_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("assembler_source_tokenizer_test NOT OK");
      $finish;
    end
  end

  function automatic void put(logic [20:0] c);
    src_q.push_back('{cp: c, eoi: 1'b0});
  endfunction

  function automatic logic [20:0] any_cp();
    return 21'($urandom_range(0, CP_MAX));
  endfunction

  function automatic logic [20:0] pick_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 21'd32 : 21'(9 + k);
  endfunction

  function automatic logic [20:0] pick_letter();
    int k;
    k = $urandom_range(0, 51);
    return (k < 26) ? 21'(65 + k) : 21'(97 + k - 26);
  endfunction

  function automatic logic [20:0] pick_digit();
    return 21'(48 + $urandom_range(0, 9));
  endfunction

  function automatic logic [20:0] pick_word_char();
    int k;
    k = $urandom_range(0, 62);
    if (k < 52) return pick_letter();
    if (k < 62) return pick_digit();
    return "_";
  endfunction

  function automatic logic [20:0] pick_plain();
    if ($urandom_range(0, 9) < 6) return 21'($urandom_range(33, 126));
    return any_cp();
  endfunction

  function automatic logic [20:0] pick_solid();
    logic [20:0] c;
    c = pick_plain();
    if (c == 21'd32 || (c >= 21'd9 && c <= 21'd13)) c = "x";
    return c;
  endfunction

  function automatic logic [20:0] pick_symbol();
    case ($urandom_range(0, 10))
      0: return "(";
      1: return ")";
      2: return "[";
      3: return "]";
      4: return ",";
      5: return "*";
      6: return "+";
      7: return "/";
      8: return "-";
      9: return "#";
      default: return PILCROW;
    endcase
  endfunction

  function automatic void put_long_token();
    int n;
    logic [20:0] c;
    n = $urandom_range(33, 40);
    case ($urandom_range(0, 3))
      0: begin
        put(pick_letter());
        repeat (n - 1) put(pick_word_char());
      end
      1: repeat (n) put(pick_digit());
      2: begin
        put("\"");
        repeat (n) begin
          c = pick_solid();
          put((c == "\"" || c == "\\") ? 21'("q") : c);
        end
        put("\"");
      end
      default: begin
        put("@");
        repeat (n) put(pick_solid());
      end
    endcase
  endfunction

  function automatic void put_token();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      put(pick_symbol());
    end else if (sel < 20) begin
      put(";");
      n = $urandom_range(0, 5);
      repeat (n) put(pick_plain());
      put(NEWLINE);
    end else if (sel < 30) begin
      put(".");
      n = $urandom_range(0, 6);
      repeat (n) put(pick_letter());
    end else if (sel < 42) begin
      put("\"");
      n = $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) put("\\");
        put(pick_plain());
      end
      put("\"");
    end else if (sel < 50) begin
      put("'");
      n = $urandom_range(0, 6);
      repeat (n) put(pick_plain());
      put("'");
    end else if (sel < 60) begin
      put("@");
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : TIMEPOINT_CHARS;
      repeat (n) put(pick_solid());
      put(pick_space());
    end else if (sel < 70) begin
      n = $urandom_range(1, 6);
      repeat (n) put(pick_digit());
    end else if (sel < 84) begin
      put(($urandom_range(0, 7) == 0) ? 21'("_") : pick_letter());
      n = $urandom_range(0, 7);
      repeat (n) put(pick_word_char());
      if ($urandom_range(0, 2) == 0) put(":");
    end else if (sel < 88) begin
      put_long_token();
    end else begin
      put(($urandom_range(0, 3) == 0) ? any_cp() : 21'($urandom_range(0, 127)));
    end
    if ($urandom_range(0, 9) < 7) put(pick_space());
  endfunction

  function automatic void build_stimulus();
    int n;
    // symbols, comment, sections, escapes, empty tokens, stray chars
    put("(");
    put(PILCROW);
    put("#");
    put(";");
    put("z");
    put(NEWLINE);
    put(".");
    put("Z");
    put(".");
    put("\"");
    put("a");
    put("\\");
    put("q");
    put(21'(CP_MAX));
    put("\"");
    put("'");
    put("'");
    put("@");
    put(21'd32);
    put(":");
    put("!");
    put("7");
    put("0");
    put("x");
    put("_");
    put(":");
    put(21'd0);
    directed_n = src_q.size();
    while (src_q.size() < directed_n + RANDOM_ITEMS) put_token();
    // leave a token open at the end mark, or none
    case ($urandom_range(0, 4))
      0: begin
        put(".");
        n = $urandom_range(0, 3);
        repeat (n) put(pick_letter());
      end
      1: repeat ($urandom_range(1, 3)) put(pick_digit());
      2: repeat ($urandom_range(1, 3)) put(pick_letter());
      3: begin
        put("\"");
        put("a");
      end
      default: ;
    endcase
    src_q.push_back('{cp: any_cp(), eoi: 1'b1});
    repeat (3) src_q.push_back('{cp: any_cp(), eoi: 1'($urandom_range(0, 1))});
  endfunction

  task automatic send_word(src_word_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, w.cp};
    s_tlast <= w.eoi;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_input(w.cp, w.eoi);
  endtask

  task automatic drain_words();
    int stall;
    token_word_t got;
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      got = '{kind: ast_pkg::kind_t'(m_tuser[2:0]), cv: m_tuser[3], ch: m_tdata[20:0],
              last: m_tlast, trunc: m_tuser[4], bad: m_tuser[5]};
      sb.check_word(got);
    end
  endtask

  initial begin
    sb = new();
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_words();
    join_none
    for (int i = 0; i < src_q.size(); i++) begin
      if (i >= directed_n && (i % 40) == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_word(src_q[i]);
    end
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("assembler_source_tokenizer_test OK");
    end else begin
      $display("assembler_source_tokenizer_test NOT OK");
    end
    $finish;
  end
endmodule

// ===== assembler_source_tokenizer.f =====
hdl/ast_pkg.sv
hdl/ast_ram.sv
hdl/ast_scan.sv
hdl/ast_descq.sv
hdl/ast_replay.sv
hdl/assembler_source_tokenizer.sv
tb/assembler_source_tokenizer_test.sv
